/* hw/rtl/flash_sector_rmw_writer_macros.svh */
// assertion macros used by the checker
`ifndef FLASH_SECTOR_RMW_WRITER_MACROS_SVH
`define FLASH_SECTOR_RMW_WRITER_MACROS_SVH

// same-cycle implication
`define FSRW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsrw check failed");

// next-cycle implication
`define FSRW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsrw check failed");

`endif

/* hw/rtl/fsrw_pkg.sv */
package fsrw_pkg;

  localparam int MAX_AW = 16;
  localparam int MAX_OW = 12;
  localparam int FIELD_AW = 13;
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_ERASE = 2'd1,
    OP_PROG  = 2'd2,
    OP_BUF   = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [MAX_AW-1:0] addr;
    logic [7:0]        data;
    logic              commit;
    logic [MAX_OW-1:0] seg_start;
  } fsrw_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ERASE,
    ST_PROG_WR,
    ST_BUF,
    ST_COPY,
    ST_COPY_LAST,
    ST_FINISH
  } state_t;

endpackage

/* hw/rtl/fsrw_queue.sv */
module fsrw_queue
  import fsrw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fsrw_op_t push_item,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output fsrw_op_t q_item
);

  fsrw_op_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && q_valid) ? 1 : 0);
    end
  end

endmodule

/* hw/rtl/fsrw_front.sv */
module fsrw_front
  import fsrw_pkg::*;
#(
  parameter int FLASH_BYTES  = 8192,
  parameter int SECTOR_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  cmd,
  input  logic [12:0] address,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        q_full,
  output logic        q_push,
  output fsrw_op_t    q_item
);

  localparam int AW = $clog2(FLASH_BYTES);
  localparam int OW = $clog2(SECTOR_BYTES);
  localparam int XW = (AW > FIELD_AW) ? AW : FIELD_AW;

  logic          run_open;
  logic [AW-1:0] run_next;
  logic [OW-1:0] seg_start;
  logic          seg_fresh;

  op_t           op;
  logic [XW-1:0] addr_ext;
  logic [AW-1:0] eff_addr;
  logic [OW-1:0] off;
  logic [OW-1:0] start;
  logic          commit;
  logic          accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_comb begin
    op       = op_t'(cmd);
    addr_ext = XW'(address);
    eff_addr = (op == OP_BUF && run_open) ? run_next : addr_ext[AW-1:0];
    off      = eff_addr[OW-1:0];
    commit   = (op == OP_BUF) && (last_byte || (&off));
    // first byte of a fresh segment marks where the sector copy begins
    start    = seg_fresh ? off : seg_start;
    q_item.op        = op;
    q_item.addr      = MAX_AW'(eff_addr);
    q_item.data      = data_byte;
    q_item.commit    = commit;
    q_item.seg_start = MAX_OW'(start);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open  <= 1'b0;
      run_next  <= '0;
      seg_start <= '0;
      seg_fresh <= 1'b1;
    end else if (accept && op == OP_BUF) begin
      run_open  <= !last_byte;
      run_next  <= eff_addr + AW'(1);
      seg_start <= start;
      seg_fresh <= commit;
    end
  end

endmodule

/* hw/rtl/fsrw_back.sv */
module fsrw_back
  import fsrw_pkg::*;
#(
  parameter int FLASH_BYTES  = 8192,
  parameter int SECTOR_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  fsrw_op_t   q_item,
  output logic       q_pop,
  output logic [7:0] read_data,
  output logic       sector_committed,
  output logic [3:0] committed_sector,
  output logic       out_valid,
  input  logic       out_ready
);

  localparam int AW = $clog2(FLASH_BYTES);
  localparam int OW = $clog2(SECTOR_BYTES);
  localparam logic [AW-1:0] OFF_MASK = AW'(SECTOR_BYTES - 1);

  logic [7:0] flash [FLASH_BYTES];
  logic [7:0] pend  [SECTOR_BYTES];

  state_t        state;
  state_t        state_next;
  fsrw_op_t      cur;
  logic [OW-1:0] cnt;
  logic [AW-1:0] clr_cnt;
  logic          pvld;
  logic [OW-1:0] poff;
  logic [7:0]    fl_rdata;
  logic [7:0]    pd_rdata;

  logic [AW-1:0] cur_a;
  logic [OW-1:0] cur_off;
  logic [AW-1:0] base;
  logic          fin_ok;

  logic          fl_we;
  logic [AW-1:0] fl_waddr;
  logic [7:0]    fl_wdata;
  logic          fl_re;
  logic [AW-1:0] fl_raddr;
  logic          pd_we;
  logic          pd_re;

  assign cur_a   = cur.addr[AW-1:0];
  assign cur_off = cur_a[OW-1:0];
  assign base    = cur_a & ~OFF_MASK;
  assign fin_ok  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (&clr_cnt) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_READ:  state_next = ST_FINISH;
            OP_ERASE: state_next = ST_ERASE;
            OP_PROG:  state_next = ST_PROG_WR;
            OP_BUF:   state_next = ST_BUF;
            default:  state_next = ST_FINISH;
          endcase
        end
      end
      ST_ERASE: begin
        if (&cnt) state_next = ST_FINISH;
      end
      ST_PROG_WR:   state_next = ST_FINISH;
      ST_BUF:       state_next = cur.commit ? ST_COPY : ST_FINISH;
      ST_COPY: begin
        if (cnt == cur_off) state_next = ST_COPY_LAST;
      end
      ST_COPY_LAST: state_next = ST_FINISH;
      ST_FINISH: begin
        if (fin_ok) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    fl_we    = 1'b0;
    fl_waddr = '0;
    fl_wdata = ERASED_BYTE;
    fl_re    = 1'b0;
    fl_raddr = q_item.addr[AW-1:0];
    pd_we    = 1'b0;
    pd_re    = 1'b0;
    case (state)
      ST_CLEAR: begin
        fl_we    = 1'b1;
        fl_waddr = clr_cnt;
      end
      ST_IDLE: begin
        q_pop = q_valid;
        fl_re = q_valid;
      end
      ST_ERASE: begin
        fl_we    = 1'b1;
        fl_waddr = base | AW'(cnt);
      end
      ST_PROG_WR: begin
        fl_we    = 1'b1;
        fl_waddr = cur_a;
        fl_wdata = fl_rdata & cur.data;
      end
      ST_BUF: begin
        pd_we = 1'b1;
      end
      ST_COPY: begin
        pd_re = 1'b1;
      end
      default: begin
      end
    endcase
    // copy pipeline: pending byte read last cycle lands in flash now
    if (pvld) begin
      fl_we    = 1'b1;
      fl_waddr = base | AW'(poff);
      fl_wdata = pd_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (fl_we) flash[fl_waddr] <= fl_wdata;
    if (fl_re) fl_rdata <= flash[fl_raddr];
  end

  always_ff @(posedge clk) begin
    if (pd_we) pend[cur_off] <= cur.data;
    if (pd_re) pd_rdata <= pend[cnt];
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
    poff <= cnt;
    case (state)
      ST_IDLE:  cnt <= '0;
      ST_BUF:   cnt <= cur.seg_start[OW-1:0];
      ST_ERASE: cnt <= cnt + OW'(1);
      ST_COPY:  cnt <= cnt + OW'(1);
      default:  cnt <= cnt;
    endcase
    if (state == ST_FINISH && fin_ok) begin
      read_data        <= (cur.op == OP_READ) ? fl_rdata : 8'd0;
      sector_committed <= (cur.op == OP_BUF) && cur.commit;
      committed_sector <= (cur.op == OP_BUF && cur.commit) ? 4'(cur_a >> OW) : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      pvld      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pvld  <= pd_re;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (state == ST_FINISH && fin_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/flash_sector_rmw_writer.sv */
// one result beat per command; read goes IDLE then FINISH, program adds PROG_WR, buffered byte BUF
// a buffered byte that closes a segment adds a copy of the segment into flash (COPY, COPY_LAST)
// erase walks every byte of the sector through the single flash write port
// a 2-deep queue lets commands be taken while the back end is busy
// reset: after rst falls the flash array is filled with 0xff, one byte a cycle,
// before the first command executes (commands still queue)
module flash_sector_rmw_writer
  import fsrw_pkg::*;
#(
  parameter int FLASH_BYTES  = 8192,
  parameter int SECTOR_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  cmd,
  input  logic [12:0] address,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [7:0]  read_data,
  output logic        sector_committed,
  output logic [3:0]  committed_sector,
  output logic        out_valid,
  input  logic        out_ready
);

  fsrw_op_t push_item;
  fsrw_op_t q_item;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;

  fsrw_front #(
    .FLASH_BYTES (FLASH_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .address  (address),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  fsrw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  fsrw_back #(
    .FLASH_BYTES (FLASH_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .read_data       (read_data),
    .sector_committed(sector_committed),
    .committed_sector(committed_sector),
    .out_valid       (out_valid),
    .out_ready       (out_ready)
  );

endmodule

/* hw/rtl/fsrw_checker.sv */
`include "flash_sector_rmw_writer_macros.svh"

module fsrw_checker (
  input logic        clk,
  input logic        rst,
  input logic [7:0]  read_data,
  input logic        sector_committed,
  input logic [3:0]  committed_sector,
  input logic        out_valid,
  input logic        out_ready
);

  // stalled result beat holds
  `FSRW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(sector_committed) && $stable(committed_sector))
  // no commit means no sector index
  `FSRW_ASSERT_NOW(a_idx_zero, clk, rst, out_valid && !sector_committed, committed_sector == 4'd0)
  // a commit beat never carries read data
  `FSRW_ASSERT_NOW(a_commit_no_data, clk, rst, out_valid && sector_committed, read_data == 8'd0)
  // nothing comes out right after reset
  `FSRW_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !out_valid)

endmodule

bind flash_sector_rmw_writer fsrw_checker u_fsrw_checker (.*);
